// ===== sv/wsp_pkg.sv =====
// Package: shared constants, codes, types and the note base table of the wavetable player.
`timescale 1ns / 1ps
package wsp_pkg;

	// Default sizing handed to the top level
	localparam int DEF_MAX_LEN_LOG2    = 10;
	localparam int DEF_PHASE_FRAC_BITS = 20;

	// Fixed sizing
	localparam int NUM_SEGMENTS  = 4;
	localparam int SEL_W         = 2;
	localparam int SAMPLE_W      = 14;
	localparam int MIX_W         = 24;
	localparam int OUT_W         = 25;
	localparam int SUM_W         = 29;
	localparam int RATE_W        = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 8;
	localparam int ROM_W         = 18;
	localparam int ROW_MAX       = 10;
	localparam int ROM_SCALE_LOG2 = 30;
	localparam int MIN_LEN_LOG2  = 4;

	// Division by twelve for notes below 132: (n * 171) >> 11
	localparam int DIV12_MUL   = 171;
	localparam int DIV12_SHIFT = 11;
	localparam int NOTE_MAX    = 131;

	// Saturation bounds of the output word
	localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(16777215);
	localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(16777216);

	// Request codes
	localparam logic [1:0] REQ_WRITE    = 2'd0;
	localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
	localparam logic [1:0] REQ_NOTE_OFF = 2'd2;
	localparam logic [1:0] REQ_SAMPLE   = 2'd3;

	// Segment codes
	localparam logic [2:0] SEG_ATTACK  = 3'd0;
	localparam logic [2:0] SEG_DECAY   = 3'd1;
	localparam logic [2:0] SEG_SUSTAIN = 3'd2;
	localparam logic [2:0] SEG_RELEASE = 3'd3;
	localparam logic [2:0] SEG_DONE    = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEN_LOG2     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_ATTACK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_DECAY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_SUSTAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_RELEASE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE    = 3'd6;

	// Segment lengths in buffers
	typedef struct packed {
		logic [RATE_W-1:0] attack;
		logic [RATE_W-1:0] decay;
		logic [RATE_W-1:0] sustain;
		logic [RATE_W-1:0] release_cnt;
	} wsp_rates_t;

	// Events handed to the envelope sequencer
	typedef struct packed {
		logic note_on;
		logic note_off;
		logic tick;
	} wsp_env_evt_t;

	// Envelope status
	typedef struct packed {
		logic [2:0] seg;
		logic       playing;
		logic       started;
	} wsp_env_t;

	// Octave-4 note increments, C through B, scaled by 2^24 / 55555
	function automatic logic [ROM_W-1:0] base_rom(input logic [3:0] k);
		logic [ROM_W-1:0] v;
		begin
			case (k)
				4'd0:    v = 18'd79016;
				4'd1:    v = 18'd83712;
				4'd2:    v = 18'd88695;
				4'd3:    v = 18'd93950;
				4'd4:    v = 18'd99537;
				4'd5:    v = 18'd105456;
				4'd6:    v = 18'd111737;
				4'd7:    v = 18'd118381;
				4'd8:    v = 18'd125418;
				4'd9:    v = 18'd132877;
				4'd10:   v = 18'd140789;
				4'd11:   v = 18'd149154;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

// ===== sv/wsp_channels.sv =====
// Interfaces: request, result and configuration channels of the wavetable player.
`timescale 1ns / 1ps

interface wsp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [1:0]  wave_sel;
	logic [9:0]  table_addr;
	logic signed [13:0] table_value;
	logic [6:0]  note;
	logic signed [23:0] mix_in;
	logic        buffer_end;

	modport source(output valid, req_type, wave_sel, table_addr, table_value, note, mix_in,
		buffer_end, input ready);
	modport sink(input valid, req_type, wave_sel, table_addr, table_value, note, mix_in,
		buffer_end, output ready);
endinterface

interface wsp_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [24:0] sample_out;
	logic [2:0]  segment;
	logic        playing;

	modport source(output valid, sample_out, segment, playing, input ready);
	modport sink(input valid, sample_out, segment, playing, output ready);
endinterface

interface wsp_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/wsp_envelope.sv =====
// Envelope sequencer: segment index, buffer countdown and playback flags.
`timescale 1ns / 1ps
module wsp_envelope (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wsp_pkg::wsp_env_evt_t evt,
	input  wsp_pkg::wsp_rates_t  rates,
	output wsp_pkg::wsp_env_t    cur,
	output wsp_pkg::wsp_env_t    nxt
);

	logic [2:0]                 seg_q, seg_d;
	logic [wsp_pkg::RATE_W-1:0] cnt_q, cnt_d;
	logic                       idle_q, idle_d;
	logic                       playing_q, playing_d;
	logic                       started_q, started_d;

	// Work out the state after this word
	always_comb begin
		seg_d     = seg_q;
		cnt_d     = cnt_q;
		idle_d    = idle_q;
		playing_d = playing_q;
		started_d = started_q;
		if (evt.note_on && !playing_q) begin
			seg_d     = wsp_pkg::SEG_ATTACK;
			cnt_d     = rates.attack;
			idle_d    = 1'b0;
			playing_d = 1'b1;
			started_d = 1'b1;
		end else if (evt.note_off && playing_q) begin
			seg_d     = wsp_pkg::SEG_RELEASE;
			cnt_d     = rates.release_cnt;
			idle_d    = 1'b0;
			playing_d = 1'b0;
		end else if (evt.tick && !idle_q) begin
			if (cnt_q != '0) begin
				cnt_d = cnt_q - 1'b1;
			end else begin
				// expired count: move on, reload sustain, or finish
				case (seg_q)
					wsp_pkg::SEG_ATTACK: begin
						seg_d = wsp_pkg::SEG_DECAY;
						cnt_d = rates.decay;
					end
					wsp_pkg::SEG_DECAY: begin
						seg_d = wsp_pkg::SEG_SUSTAIN;
						cnt_d = rates.sustain;
					end
					wsp_pkg::SEG_SUSTAIN: begin
						cnt_d = rates.sustain;
					end
					default: begin
						seg_d  = wsp_pkg::SEG_DONE;
						cnt_d  = '0;
						idle_d = 1'b1;
					end
				endcase
			end
		end
	end

	// Hold the envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= wsp_pkg::SEG_ATTACK;
			cnt_q     <= '0;
			idle_q    <= 1'b0;
			playing_q <= 1'b0;
			started_q <= 1'b0;
		end else begin
			seg_q     <= seg_d;
			cnt_q     <= cnt_d;
			idle_q    <= idle_d;
			playing_q <= playing_d;
			started_q <= started_d;
		end
	end

	assign cur = '{seg: seg_q, playing: playing_q, started: started_q};
	assign nxt = '{seg: seg_d, playing: playing_d, started: started_d};

endmodule

// ===== sv/wavetable_segment_player_unit.sv =====
// Top level: wavetable segment player with table memory, phase accumulator and output stage.
//
//  channel | dir | handshake       | carries
//  req     | in  | valid / ready   | req_type, wave_sel, table_addr, table_value, note,
//          |     |                 | mix_in, buffer_end
//  rsp     | out | valid / ready   | sample_out, segment, playing (one word per sample)
//  cfg     | in  | valid / ready   | index, data (ready always high)
//
// One request word a cycle while req.ready is high. A sample word reads the table memory
// on acceptance, and its result word enters the output register once the output frees
// up; the table memory's single read port and the phase accumulator set the one-word-a-cycle rate.
// Reset clears control state; table contents stay undefined until written.
// A stalled output stops the read stage, and req.ready falls only while both are full.
`timescale 1ns / 1ps
module wavetable_segment_player_unit #(
	parameter int MAX_LEN_LOG2    = wsp_pkg::DEF_MAX_LEN_LOG2,
	parameter int PHASE_FRAC_BITS = wsp_pkg::DEF_PHASE_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	wsp_req_if.sink      req,
	wsp_rsp_if.source    rsp,
	wsp_cfg_if.sink      cfg
);

	localparam int PHASE_W  = MAX_LEN_LOG2 + PHASE_FRAC_BITS;
	localparam int POS_W    = $clog2(PHASE_W + 1);
	localparam int ADDR_W   = wsp_pkg::SEL_W + MAX_LEN_LOG2;
	localparam int DEPTH    = wsp_pkg::NUM_SEGMENTS << MAX_LEN_LOG2;
	localparam int SHAMT_W  = $clog2(MAX_LEN_LOG2 + wsp_pkg::ROW_MAX + 1);
	localparam int FULL_W   = wsp_pkg::ROM_W + MAX_LEN_LOG2 + wsp_pkg::ROW_MAX;
	localparam int STEP_DROP = wsp_pkg::ROM_SCALE_LOG2 - PHASE_FRAC_BITS;

	// ---------------- configuration registers ----------------
	logic [3:0]                     bit_depth_q;
	logic [3:0]                     len_log2_q;
	wsp_pkg::wsp_rates_t            rates_q;
	logic [wsp_pkg::CFG_DATA_W-1:0] transpose_q;

	assign cfg.ready = 1'b1;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q         <= 4'd8;
			len_log2_q          <= 4'd5;
			rates_q.attack      <= 8'd0;
			rates_q.decay       <= 8'd1;
			rates_q.sustain     <= 8'd4;
			rates_q.release_cnt <= 8'd4;
			transpose_q         <= 8'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				wsp_pkg::CFG_BIT_DEPTH:    bit_depth_q         <= cfg.data[3:0];
				wsp_pkg::CFG_LEN_LOG2:     len_log2_q          <= cfg.data[3:0];
				wsp_pkg::CFG_RATE_ATTACK:  rates_q.attack      <= cfg.data;
				wsp_pkg::CFG_RATE_DECAY:   rates_q.decay       <= cfg.data;
				wsp_pkg::CFG_RATE_SUSTAIN: rates_q.sustain     <= cfg.data;
				wsp_pkg::CFG_RATE_RELEASE: rates_q.release_cnt <= cfg.data;
				wsp_pkg::CFG_TRANSPOSE:    transpose_q         <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic acc;
	logic is_write, is_note_on, is_note_off, is_sample;

	assign advance    = !out_valid_q || rsp.ready;
	assign req.ready  = !valid_s1 || advance;
	assign acc        = req.valid && req.ready;
	assign is_write    = acc && (req.req_type == wsp_pkg::REQ_WRITE);
	assign is_note_on  = acc && (req.req_type == wsp_pkg::REQ_NOTE_ON);
	assign is_note_off = acc && (req.req_type == wsp_pkg::REQ_NOTE_OFF);
	assign is_sample   = acc && (req.req_type == wsp_pkg::REQ_SAMPLE);

	// ---------------- envelope ----------------
	wsp_pkg::wsp_env_evt_t env_evt;
	wsp_pkg::wsp_env_t     env_cur;
	wsp_pkg::wsp_env_t     env_nxt;

	assign env_evt = '{note_on: is_note_on, note_off: is_note_off,
		tick: is_sample && req.buffer_end};

	wsp_envelope u_env (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (env_evt),
		.rates  (rates_q),
		.cur    (env_cur),
		.nxt    (env_nxt)
	);

	// ---------------- note-on increment ----------------
	logic signed [8:0] note_sum;
	logic [7:0]        note_c;
	logic [15:0]       div_prod;
	logic [3:0]        row;
	logic [3:0]        semi;
	logic [3:0]        bd_c;
	logic [3:0]        len_c;
	logic [SHAMT_W-1:0] shamt;
	logic [FULL_W-1:0] step_full;
	logic [PHASE_W-1:0] step_new;

	always_comb begin
		// clamp note plus transpose to the table range
		note_sum = $signed({2'b00, req.note}) + $signed({transpose_q[7], transpose_q});
		if (note_sum < 0) begin
			note_c = '0;
		end else if (note_sum > 9'sd131) begin
			note_c = 8'(wsp_pkg::NOTE_MAX);
		end else begin
			note_c = note_sum[7:0];
		end
		// split into octave row and semitone
		div_prod = 16'(note_c) * 16'(wsp_pkg::DIV12_MUL);
		row      = 4'(div_prod >> wsp_pkg::DIV12_SHIFT);
		semi     = 4'(note_c - 8'(row) * 8'd12);
		// clamp latched depth and length
		bd_c = bit_depth_q;
		if (bd_c < 4'd1) bd_c = 4'd1;
		if (bd_c > 4'(wsp_pkg::SAMPLE_W)) bd_c = 4'(wsp_pkg::SAMPLE_W);
		len_c = len_log2_q;
		if (len_c < 4'(wsp_pkg::MIN_LEN_LOG2)) len_c = 4'(wsp_pkg::MIN_LEN_LOG2);
		if (len_c > 4'(MAX_LEN_LOG2)) len_c = 4'(MAX_LEN_LOG2);
		shamt     = SHAMT_W'(len_c) + SHAMT_W'(row);
		step_full = FULL_W'(wsp_pkg::base_rom(semi)) << shamt;
		step_new  = PHASE_W'(step_full >> STEP_DROP);
	end

	// ---------------- phase accumulator ----------------
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] step_q;
	logic [3:0]         shift_q;
	logic [3:0]         len_q;
	logic               active;
	logic [PHASE_W:0]   phase_sum;
	logic [PHASE_W:0]   wrap_mask;
	logic [POS_W-1:0]   wrap_pos;
	logic [PHASE_W-1:0] phase_next;

	assign active     = env_cur.started && (env_cur.seg < 3'(wsp_pkg::NUM_SEGMENTS));
	assign phase_sum  = {1'b0, phase_q} + {1'b0, step_q};
	assign wrap_pos   = POS_W'(len_q) + POS_W'(PHASE_FRAC_BITS);
	assign wrap_mask  = (PHASE_W+1)'(1) << wrap_pos;
	// sum stays below twice the period, so wrapping clears the period bit
	assign phase_next = PHASE_W'(phase_sum & ~wrap_mask);

	// Advance phase, latch note-on settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			shift_q <= 4'd6;
			len_q   <= 4'd5;
		end else if (is_note_on && !env_cur.playing) begin
			phase_q <= '0;
			step_q  <= step_new;
			shift_q <= 4'(wsp_pkg::SAMPLE_W) - bd_c;
			len_q   <= len_c;
		end else if (is_sample && active) begin
			phase_q <= phase_next;
		end
	end

	// ---------------- wave table memory ----------------
	logic [wsp_pkg::SAMPLE_W-1:0] wave_mem [DEPTH];
	logic [wsp_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic [ADDR_W-1:0]            wr_addr;
	logic [ADDR_W-1:0]            rd_addr;

	assign wr_addr = {req.wave_sel, req.table_addr[MAX_LEN_LOG2-1:0]};
	assign rd_addr = {env_cur.seg[1:0], phase_q[PHASE_W-1:PHASE_FRAC_BITS]};

	// Write table entries
	always_ff @(posedge clk) begin
		if (is_write) begin
			wave_mem[wr_addr] <= req.table_value;
		end
	end

	// Read the current entry for a sample word
	always_ff @(posedge clk) begin
		if (is_sample) begin
			rd_data_s1 <= wave_mem[rd_addr];
		end
	end

	// ---------------- read stage ----------------
	logic                            active_s1;
	logic [3:0]                      shift_s1;
	logic signed [wsp_pkg::MIX_W-1:0] mix_s1;
	logic [2:0]                      seg_s1;
	logic                            play_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= is_sample;
		end
	end

	// Capture sample word context
	always_ff @(posedge clk) begin
		if (is_sample) begin
			active_s1 <= active;
			shift_s1  <= shift_q;
			mix_s1    <= req.mix_in;
			seg_s1    <= env_nxt.seg;
			play_s1   <= env_nxt.playing;
		end
	end

	// ---------------- mix and saturate ----------------
	logic signed [wsp_pkg::SUM_W-1:0] entry_ext;
	logic signed [wsp_pkg::SUM_W-1:0] mix_ext;
	logic signed [wsp_pkg::SUM_W-1:0] mix_sum;
	logic signed [wsp_pkg::OUT_W-1:0] sample_d;

	always_comb begin
		entry_ext = {{(wsp_pkg::SUM_W-wsp_pkg::SAMPLE_W){rd_data_s1[wsp_pkg::SAMPLE_W-1]}},
			rd_data_s1};
		mix_ext   = {{(wsp_pkg::SUM_W-wsp_pkg::MIX_W){mix_s1[wsp_pkg::MIX_W-1]}}, mix_s1};
		mix_sum   = (entry_ext <<< shift_s1) + mix_ext;
		if (!active_s1) begin
			sample_d = '0;
		end else if (mix_sum > wsp_pkg::OUT_MAX) begin
			sample_d = wsp_pkg::OUT_W'(wsp_pkg::OUT_MAX);
		end else if (mix_sum < wsp_pkg::OUT_MIN) begin
			sample_d = wsp_pkg::OUT_W'(wsp_pkg::OUT_MIN);
		end else begin
			sample_d = wsp_pkg::OUT_W'(mix_sum);
		end
	end

	// ---------------- output register ----------------
	logic signed [wsp_pkg::OUT_W-1:0] sample_q;
	logic [2:0]                       seg_q;
	logic                             play_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Load result word when the output frees up
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			sample_q <= sample_d;
			seg_q    <= seg_s1;
			play_q   <= play_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.sample_out = sample_q;
	assign rsp.segment    = seg_q;
	assign rsp.playing    = play_q;

endmodule
